[design/stl_pkg.sv]
// Package for the source tokenizer: token type, kind codes, character classes.
`default_nettype none
package stl_pkg;

   localparam int STL_POS_BITS    = 20;
   localparam int STL_LINE_BITS   = 16;
   localparam int STL_QUEUE_DEPTH = 8;

   localparam int STL_KIND_W = 5;
   localparam int STL_POS_W  = 20;
   localparam int STL_LINE_W = 16;
   localparam int STL_MAX_TOK = 3;

   localparam logic [STL_KIND_W-1:0] K_LPAREN  = 5'd0;
   localparam logic [STL_KIND_W-1:0] K_RPAREN  = 5'd1;
   localparam logic [STL_KIND_W-1:0] K_LBRACE  = 5'd2;
   localparam logic [STL_KIND_W-1:0] K_RBRACE  = 5'd3;
   localparam logic [STL_KIND_W-1:0] K_SEMI    = 5'd4;
   localparam logic [STL_KIND_W-1:0] K_COMMA   = 5'd5;
   localparam logic [STL_KIND_W-1:0] K_DOT     = 5'd6;
   localparam logic [STL_KIND_W-1:0] K_MINUS   = 5'd7;
   localparam logic [STL_KIND_W-1:0] K_PLUS    = 5'd8;
   localparam logic [STL_KIND_W-1:0] K_SLASH   = 5'd9;
   localparam logic [STL_KIND_W-1:0] K_STAR    = 5'd10;
   localparam logic [STL_KIND_W-1:0] K_BANG    = 5'd11;
   localparam logic [STL_KIND_W-1:0] K_EQUAL   = 5'd13;
   localparam logic [STL_KIND_W-1:0] K_LESS    = 5'd15;
   localparam logic [STL_KIND_W-1:0] K_GREATER = 5'd17;
   localparam logic [STL_KIND_W-1:0] K_STRING  = 5'd19;
   localparam logic [STL_KIND_W-1:0] K_NUMBER  = 5'd20;
   localparam logic [STL_KIND_W-1:0] K_IDENT   = 5'd21;
   localparam logic [STL_KIND_W-1:0] K_EOF     = 5'd22;
   localparam logic [STL_KIND_W-1:0] K_ERROR   = 5'd23;

   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef struct packed {
      logic [STL_LINE_W-1:0] line;
      logic [STL_POS_W-1:0]  length;
      logic [STL_POS_W-1:0]  start;
      logic [STL_KIND_W-1:0] kind;
      logic                  last;
   } stl_tok_type;

   typedef struct packed {
      logic                        valid;
      logic [1:0]                  count;
      stl_tok_type [STL_MAX_TOK-1:0] toks;
   } stl_push_type;

   typedef enum logic [8:0] {
      MODE_IDLE     = 9'b000000001,
      MODE_IDENT    = 9'b000000010,
      MODE_NUMBER   = 9'b000000100,
      MODE_NUMDOT   = 9'b000001000,
      MODE_FRACTION = 9'b000010000,
      MODE_STRING   = 9'b000100000,
      MODE_SLASH    = 9'b001000000,
      MODE_COMMENT  = 9'b010000000,
      MODE_OPER     = 9'b100000000
   } stl_mode_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             (c == CH_UNDER);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) ||
             (c == CH_FF);
   endfunction

   function automatic logic [STL_KIND_W-1:0] punct_kind(input logic [7:0] c);
      logic [STL_KIND_W-1:0] k;
      case (c)
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h7B:   k = K_LBRACE;
         8'h7D:   k = K_RBRACE;
         8'h3B:   k = K_SEMI;
         8'h2C:   k = K_COMMA;
         CH_DOT:  k = K_DOT;
         8'h2D:   k = K_MINUS;
         8'h2B:   k = K_PLUS;
         8'h2A:   k = K_STAR;
         default: k = K_ERROR;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

[design/stl_scan.sv]
// Scanner: input register, scan state and per-byte token generation.
`default_nettype none
module stl_scan
   import stl_pkg::*;
#(
   parameter int POS_BITS  = STL_POS_BITS,
   parameter int LINE_BITS = STL_LINE_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   ch,
   input  wire logic         end_of_input,
   output stl_push_type      push
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           ch_ff;
   logic                 eoi_ff;

   stl_mode_type         mode_ff, mode_in;
   logic [STL_KIND_W-1:0] pend_ff, pend_in;
   logic [POS_BITS-1:0]  start_ff, start_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 ended_ff, ended_in;

   logic [POS_BITS-1:0]  pos_p1;
   logic [POS_BITS-1:0]  dot_pos;
   logic [LINE_BITS-1:0] line_p1;
   logic                 ending;
   logic                 do_idle;
   logic [1:0]           cnt;
   stl_tok_type          tok [STL_MAX_TOK];

   function automatic stl_tok_type make_tok(input logic [STL_KIND_W-1:0] kind,
                                            input logic [POS_BITS-1:0] from,
                                            input logic [POS_BITS-1:0] to,
                                            input logic [LINE_BITS-1:0] line);
      stl_tok_type t;
      logic [POS_BITS-1:0] len;
      len      = (to >= from) ? (to - from) : '0;
      t.kind   = kind;
      t.start  = STL_POS_W'(from);
      t.length = STL_POS_W'(len);
      t.line   = STL_LINE_W'(line);
      t.last   = 1'b0;
      return t;
   endfunction

   assign in_valid_in = accept;
   assign pos_p1  = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign line_p1 = (line_ff == '1) ? line_ff : line_ff + 1'b1;
   assign dot_pos = (pos_ff > start_ff) ? pos_ff - 1'b1 : pos_ff;
   assign ending  = eoi_ff || (ch_ff == CH_NUL);

   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      ended_in = ended_ff;
      do_idle  = 1'b0;
      cnt      = 2'd0;
      for (int i = 0; i < STL_MAX_TOK; i++) begin
         tok[i] = '0;
      end

      if (ended_ff) begin
         tok[cnt] = make_tok(K_EOF, pos_ff, pos_ff, line_ff);
         cnt = cnt + 2'd1;
      end else if (ending) begin
         case (mode_ff)
            MODE_IDENT: begin
               tok[cnt] = make_tok(K_IDENT, start_ff, pos_ff, line_ff);
               cnt = cnt + 2'd1;
            end
            MODE_NUMBER, MODE_FRACTION: begin
               tok[cnt] = make_tok(K_NUMBER, start_ff, pos_ff, line_ff);
               cnt = cnt + 2'd1;
            end
            MODE_NUMDOT: begin
               tok[cnt] = make_tok(K_NUMBER, start_ff, dot_pos, line_ff);
               cnt = cnt + 2'd1;
               tok[cnt] = make_tok(K_DOT, dot_pos, pos_ff, line_ff);
               cnt = cnt + 2'd1;
            end
            MODE_STRING: begin
               tok[cnt] = make_tok(K_ERROR, start_ff, pos_ff, line_ff);
               cnt = cnt + 2'd1;
            end
            MODE_SLASH: begin
               tok[cnt] = make_tok(K_SLASH, start_ff, pos_ff, line_ff);
               cnt = cnt + 2'd1;
            end
            MODE_OPER: begin
               tok[cnt] = make_tok(pend_ff, start_ff, pos_ff, line_ff);
               cnt = cnt + 2'd1;
            end
            default: begin
            end
         endcase
         tok[cnt] = make_tok(K_EOF, pos_ff, pos_ff, line_ff);
         cnt = cnt + 2'd1;
         mode_in  = MODE_IDLE;
         ended_in = 1'b1;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (!(is_alpha(ch_ff) || is_digit(ch_ff))) begin
                  tok[cnt] = make_tok(K_IDENT, start_ff, pos_ff, line_ff);
                  cnt = cnt + 2'd1;
                  do_idle = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (ch_ff == CH_DOT) begin
                  mode_in = MODE_NUMDOT;
               end else if (!is_digit(ch_ff)) begin
                  tok[cnt] = make_tok(K_NUMBER, start_ff, pos_ff, line_ff);
                  cnt = cnt + 2'd1;
                  do_idle = 1'b1;
               end
            end
            MODE_NUMDOT: begin
               if (is_digit(ch_ff)) begin
                  mode_in = MODE_FRACTION;
               end else begin
                  tok[cnt] = make_tok(K_NUMBER, start_ff, dot_pos, line_ff);
                  cnt = cnt + 2'd1;
                  tok[cnt] = make_tok(K_DOT, dot_pos, pos_ff, line_ff);
                  cnt = cnt + 2'd1;
                  do_idle = 1'b1;
               end
            end
            MODE_FRACTION: begin
               if (!is_digit(ch_ff)) begin
                  tok[cnt] = make_tok(K_NUMBER, start_ff, pos_ff, line_ff);
                  cnt = cnt + 2'd1;
                  do_idle = 1'b1;
               end
            end
            MODE_STRING: begin
               if (ch_ff == CH_QUOTE) begin
                  tok[cnt] = make_tok(K_STRING, start_ff, pos_p1, line_ff);
                  cnt = cnt + 2'd1;
                  mode_in = MODE_IDLE;
               end else if (ch_ff == CH_NL) begin
                  line_in = line_p1;
               end
            end
            MODE_SLASH: begin
               if (ch_ff == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  tok[cnt] = make_tok(K_SLASH, start_ff, pos_ff, line_ff);
                  cnt = cnt + 2'd1;
                  do_idle = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (ch_ff == CH_NL) begin
                  line_in = line_p1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_OPER: begin
               if (ch_ff == CH_EQUAL) begin
                  tok[cnt] = make_tok(pend_ff + 1'b1, start_ff, pos_p1, line_ff);
                  cnt = cnt + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  tok[cnt] = make_tok(pend_ff, start_ff, pos_ff, line_ff);
                  cnt = cnt + 2'd1;
                  do_idle = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // start a fresh token with the current byte
         if (do_idle) begin
            mode_in  = MODE_IDLE;
            start_in = pos_ff;
            if (is_space(ch_ff)) begin
               mode_in = MODE_IDLE;
            end else if (ch_ff == CH_NL) begin
               line_in = line_p1;
            end else if (is_alpha(ch_ff)) begin
               mode_in = MODE_IDENT;
            end else if (is_digit(ch_ff)) begin
               mode_in = MODE_NUMBER;
            end else if (ch_ff == CH_QUOTE) begin
               mode_in = MODE_STRING;
            end else if (ch_ff == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (ch_ff == CH_BANG) begin
               mode_in = MODE_OPER;
               pend_in = K_BANG;
            end else if (ch_ff == CH_EQUAL) begin
               mode_in = MODE_OPER;
               pend_in = K_EQUAL;
            end else if (ch_ff == CH_LESS) begin
               mode_in = MODE_OPER;
               pend_in = K_LESS;
            end else if (ch_ff == CH_GREAT) begin
               mode_in = MODE_OPER;
               pend_in = K_GREATER;
            end else begin
               tok[cnt] = make_tok(punct_kind(ch_ff), pos_ff, pos_p1, line_ff);
               cnt = cnt + 2'd1;
            end
         end
         pos_in = pos_p1;
      end

      case (cnt)
         2'd1:    tok[0].last = 1'b1;
         2'd2:    tok[1].last = 1'b1;
         2'd3:    tok[2].last = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      push.valid = in_valid_ff && (cnt != 2'd0);
      push.count = cnt;
      for (int i = 0; i < STL_MAX_TOK; i++) begin
         push.toks[i] = tok[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         pend_ff     <= '0;
         start_ff    <= '0;
         pos_ff      <= '0;
         line_ff     <= LINE_BITS'(1);
         ended_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (in_valid_ff) begin
            mode_ff  <= mode_in;
            pend_ff  <= pend_in;
            start_ff <= start_in;
            pos_ff   <= pos_in;
            line_ff  <= line_in;
            ended_ff <= ended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff  <= ch;
         eoi_ff <= end_of_input;
      end
   end

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line count reached zero");

   a_ended_idle: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> mode_ff == MODE_IDLE)
      else $error("scan mode active after end of input");

   a_ended_eof: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && ended_ff) |-> (push.valid && push.count == 2'd1 &&
                                     push.toks[0].kind == K_EOF))
      else $error("byte after end did not give a single EOF");

endmodule
`default_nettype wire

[design/stl_queue.sv]
// Token queue: takes up to three tokens per cycle, gives one per cycle on out_ready.
`default_nettype none
module stl_queue
   import stl_pkg::*;
#(
   parameter int QUEUE_DEPTH = STL_QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire stl_push_type push,
   output logic        room,
   output logic        out_valid,
   input  wire logic   out_ready,
   output stl_tok_type out_tok
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   stl_tok_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         push_n;
   logic               pop;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] k);
      logic [PTR_W:0] s;
      s = {1'b0, p} + (PTR_W + 1)'(k);
      if (s >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
         s = s - (PTR_W + 1)'(QUEUE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   assign push_n    = push.valid ? push.count : 2'd0;
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_tok   = mem[head_ff];
   assign room      = ({1'b0, count_ff} + (CNT_W + 1)'(push_n)) <=
                      (CNT_W + 1)'(QUEUE_DEPTH - STL_MAX_TOK);
   assign head_in   = pop ? wrap_add(head_ff, 2'd1) : head_ff;
   assign tail_in   = wrap_add(tail_ff, push_n);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STL_MAX_TOK; i++) begin
         if (2'(i) < push_n) begin
            mem[wrap_add(tail_ff, 2'(i))] <= push.toks[i];
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> ({1'b0, count_ff} + (CNT_W + 1)'(push_n)) <=
                     (CNT_W + 1)'(QUEUE_DEPTH))
      else $error("token queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("token count out of range");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.valid && count_ff == CNT_W'(1)) |=> !out_valid)
      else $error("queue not empty after last token left");

endmodule
`default_nettype wire

[design/source_tokenizer_top.sv]
// Top level of the source tokenizer: stream ports, scanner and token queue.
// Path: an accepted byte is registered in the scanner input register, its tokens are written
//   into the token queue, and the queue head drives rsp.
// Throughput: one byte per cycle while the token queue can take three more tokens;
//   tokens leave one per cycle while rsp_tready is high; bytes giving 2 or 3 tokens add backlog.
// Reset: synchronous; clears scan state, position to 0, line to 1, and empties the queue.
`default_nettype none
module source_tokenizer_top
   import stl_pkg::*;
#(
   parameter int POS_BITS    = STL_POS_BITS,
   parameter int LINE_BITS   = STL_LINE_BITS,
   parameter int QUEUE_DEPTH = STL_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [4:0] kind, [24:5] start, [44:25] length,
                                         // [60:45] line, [63:61] zero
   output logic             rsp_tlast    // last token from one input byte
);

   stl_push_type push;
   stl_tok_type  out_tok;
   logic         room;

   assign req_tready = room;

   stl_scan #(
      .POS_BITS  (POS_BITS),
      .LINE_BITS (LINE_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_tvalid && req_tready),
      .ch           (req_tdata),
      .end_of_input (req_tlast),
      .push         (push)
   );

   stl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok)
   );

   assign rsp_tdata = {3'b000, out_tok.line, out_tok.length, out_tok.start, out_tok.kind};
   assign rsp_tlast = out_tok.last;

endmodule
`default_nettype wire
